[rtl/core/tmcm_pkg.sv]
// ----------------------------------------------------------------------------
// Template match package
// Shared types and constants for the template matcher.
// ----------------------------------------------------------------------------
package tmcm_pkg;

    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 11;

    localparam logic [CfgIdxW-1:0] REG_COLOR_MARGIN    = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_TEMPLATE_WIDTH  = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_TEMPLATE_HEIGHT = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_SCREEN_WIDTH    = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_SCREEN_HEIGHT   = 3'd4;

    localparam logic CMD_TEMPLATE = 1'b0;
    localparam logic CMD_SCREEN   = 1'b1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SETUP,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } tmcm_state_t;

    // controller to datapath
    typedef struct packed {
        logic load_wr;     // write accepted pixel
        logic setup;       // latch sizes, clear scan counters
        logic check;       // evaluate read data, advance scan
        logic set_result;  // capture result
    } tmcm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic no_fit;      // template larger than screen
        logic mismatch;    // current pixel pair differs
        logic tpl_end;     // last pixel of current placement
        logic place_end;   // last placement
    } tmcm_status_t;

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        abs_diff = (a > b) ? a - b : b - a;
    endfunction

endpackage

[rtl/core/tmcm_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module tmcm_ram #(
    parameter int Width = 24,
    parameter int Depth = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/core/tmcm_datapath.sv]
// ----------------------------------------------------------------------------
// Template match datapath
// Stores, write pointers, scan counters and the pixel compare.
// ----------------------------------------------------------------------------
module tmcm_datapath import tmcm_pkg::*; #(
    parameter int TemplateMaxW = 64,
    parameter int TemplateMaxH = 64,
    parameter int ScreenMaxW = 1024,
    parameter int ScreenMaxH = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  tmcm_cmd_t    cmd,
    input  logic         pix_cmd,
    input  logic [23:0]  pix_rgb,
    input  logic         pix_last,
    input  logic [7:0]   color_margin,
    input  logic [6:0]   template_width,
    input  logic [6:0]   template_height,
    input  logic [10:0]  screen_width,
    input  logic [10:0]  screen_height,
    output tmcm_status_t status,
    output logic         found
);
    localparam int TDepth = TemplateMaxW * TemplateMaxH;
    localparam int SDepth = ScreenMaxW * ScreenMaxH;
    localparam int TAW = (TDepth > 1) ? $clog2(TDepth) : 1;
    localparam int SAW = (SDepth > 1) ? $clog2(SDepth) : 1;
    localparam int TCW = $clog2(TemplateMaxW + 1) > $clog2(TemplateMaxH + 1) ?
                         $clog2(TemplateMaxW + 1) : $clog2(TemplateMaxH + 1);
    localparam int SCW = $clog2(ScreenMaxW + 1) > $clog2(ScreenMaxH + 1) ?
                         $clog2(ScreenMaxW + 1) : $clog2(ScreenMaxH + 1);
    localparam int MW = (TCW > 7 ? TCW : 7) > (SCW > 11 ? SCW : 11) ?
                        (TCW > 7 ? TCW : 7) : (SCW > 11 ? SCW : 11);

    logic [TAW-1:0] t_waddr_reg;
    logic [SAW-1:0] s_waddr_reg;

    logic [TCW-1:0] tw_reg, th_reg, tx_reg, ty_reg;
    logic [SCW-1:0] sw_reg, sh_reg, x0_reg, y0_reg;
    logic [TAW-1:0] t_raddr_reg;     // ty*tw + tx
    logic [SAW-1:0] s_row_reg;       // (y0+ty)*sw
    logic [SAW-1:0] s_base_reg;      // y0*sw
    logic           found_reg;

    logic [23:0] t_rdata, s_rdata;
    logic [SAW-1:0] s_raddr;

    function automatic logic [MW-1:0] clamp(input logic [MW-1:0] v, input logic [MW-1:0] mx);
        if (v == '0) clamp = MW'(1);
        else if (v > mx) clamp = mx;
        else clamp = v;
    endfunction

    logic [MW-1:0] tw_c, th_c, sw_c, sh_c;
    assign tw_c = clamp(MW'(template_width), MW'(TemplateMaxW));
    assign th_c = clamp(MW'(template_height), MW'(TemplateMaxH));
    assign sw_c = clamp(MW'(screen_width), MW'(ScreenMaxW));
    assign sh_c = clamp(MW'(screen_height), MW'(ScreenMaxH));

    tmcm_ram #(.Width(24), .Depth(TDepth)) u_tram (
        .aclk (aclk),
        .we   (cmd.load_wr && pix_cmd == CMD_TEMPLATE),
        .waddr(t_waddr_reg),
        .wdata(pix_rgb),
        .raddr(t_raddr_reg),
        .rdata(t_rdata)
    );

    assign s_raddr = s_row_reg + SAW'(x0_reg) + SAW'(tx_reg);

    tmcm_ram #(.Width(24), .Depth(SDepth)) u_sram (
        .aclk (aclk),
        .we   (cmd.load_wr && pix_cmd == CMD_SCREEN),
        .waddr(s_waddr_reg),
        .wdata(pix_rgb),
        .raddr(s_raddr),
        .rdata(s_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t_waddr_reg <= '0;
            s_waddr_reg <= '0;
        end else if (cmd.load_wr) begin
            if (pix_cmd == CMD_TEMPLATE) begin
                if (pix_last || 32'(t_waddr_reg) == TDepth - 1) t_waddr_reg <= '0;
                else t_waddr_reg <= t_waddr_reg + 1'b1;
            end else begin
                if (pix_last || 32'(s_waddr_reg) == SDepth - 1) s_waddr_reg <= '0;
                else s_waddr_reg <= s_waddr_reg + 1'b1;
            end
        end
    end

    logic mis_next;
    assign mis_next = abs_diff(s_rdata[23:16], t_rdata[23:16]) > color_margin ||
                      abs_diff(s_rdata[15:8],  t_rdata[15:8])  > color_margin ||
                      abs_diff(s_rdata[7:0],   t_rdata[7:0])   > color_margin;

    logic tx_end, ty_end, x_end, y_end;
    assign tx_end = tx_reg == tw_reg - 1'b1;
    assign ty_end = ty_reg == th_reg - 1'b1;
    assign x_end  = SCW'(x0_reg + SCW'(tw_reg)) == sw_reg;
    assign y_end  = SCW'(y0_reg + SCW'(th_reg)) == sh_reg;

    assign status.no_fit    = SCW'(tw_reg) > sw_reg || SCW'(th_reg) > sh_reg;
    assign status.mismatch  = mis_next;
    assign status.tpl_end   = tx_end && ty_end;
    assign status.place_end = x_end && y_end;

    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            tw_reg <= TCW'(tw_c);
            th_reg <= TCW'(th_c);
            sw_reg <= SCW'(sw_c);
            sh_reg <= SCW'(sh_c);
            tx_reg <= '0;
            ty_reg <= '0;
            x0_reg <= '0;
            y0_reg <= '0;
            t_raddr_reg <= '0;
            s_row_reg <= '0;
            s_base_reg <= '0;
        end else if (cmd.check) begin
            // restart template at next placement on mismatch or completion
            if (mis_next || (tx_end && ty_end)) begin
                tx_reg <= '0;
                ty_reg <= '0;
                t_raddr_reg <= '0;
                if (x_end) begin
                    x0_reg <= '0;
                    y0_reg <= y0_reg + 1'b1;
                    s_base_reg <= s_base_reg + SAW'(sw_reg);
                    s_row_reg <= s_base_reg + SAW'(sw_reg);
                end else begin
                    x0_reg <= x0_reg + 1'b1;
                    s_row_reg <= s_base_reg;
                end
            end else if (tx_end) begin
                tx_reg <= '0;
                ty_reg <= ty_reg + 1'b1;
                t_raddr_reg <= t_raddr_reg + 1'b1;
                s_row_reg <= s_row_reg + SAW'(sw_reg);
            end else begin
                tx_reg <= tx_reg + 1'b1;
                t_raddr_reg <= t_raddr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.set_result) found_reg <= !status.no_fit && !mis_next;
    end
    assign found = found_reg;
endmodule

[rtl/core/tmcm_ctrl.sv]
// ----------------------------------------------------------------------------
// Template match controller
// Sequences loading, the placement scan and the result handshake.
// ----------------------------------------------------------------------------
module tmcm_ctrl import tmcm_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    input  logic         s_cmd,
    input  logic         s_last_pixel,
    output logic         s_ready,
    output logic         m_valid,
    input  logic         m_ready,
    input  tmcm_status_t status,
    output tmcm_cmd_t    cmd,
    output tmcm_state_t  state
);
    tmcm_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_LOAD;
        else state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_wr = 1'b1;
                    if (s_cmd == CMD_SCREEN && s_last_pixel) begin
                        cmd.setup = 1'b1;
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP: begin
                if (status.no_fit) begin
                    cmd.set_result = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_READ: state_next = ST_CHECK;  // wait for registered read
            ST_CHECK: begin
                if (!status.mismatch && status.tpl_end) begin
                    cmd.set_result = 1'b1;
                    state_next = ST_DONE;
                end else if (status.mismatch && status.place_end) begin
                    cmd.set_result = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    cmd.check = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_DONE: begin
                m_valid = 1'b1;
                if (m_ready) state_next = ST_LOAD;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    assign state = state_reg;
endmodule

[rtl/core/template_match_with_color_margin.sv]
// ----------------------------------------------------------------------------
// Template match with color margin
// Exhaustive template search over a stored screen with per-channel tolerance.
// ----------------------------------------------------------------------------
// channel | ports                                  | direction
// s_      | s_valid s_ready s_cmd s_pixel_rgb s_last_pixel | in
// m_      | m_valid m_ready m_found                | out
// cfg     | cfg_we cfg_index cfg_data              | in
//
// Loading accepts one pixel per cycle in the load state. The search after the
// final screen pixel passes the setup state, then a registered RAM read and a
// compare for each compared pixel pair, over all tried placements until a
// match or the end; a template larger than the screen ends after setup.
// Reset clears the write pointers and the controller; stores are not cleared.
// s_ready is low during the search and while the result waits on m_ready.
module template_match_with_color_margin import tmcm_pkg::*; #(
    parameter int TemplateMaxW = 64,
    parameter int TemplateMaxH = 64,
    parameter int ScreenMaxW = 1024,
    parameter int ScreenMaxH = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_cmd,
    input  logic [23:0]         s_pixel_rgb,
    input  logic                s_last_pixel,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_found,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data
);
    logic [7:0]  color_margin_reg;
    logic [6:0]  template_width_reg, template_height_reg;
    logic [10:0] screen_width_reg, screen_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_margin_reg    <= 8'd10;
            template_width_reg  <= 7'd1;
            template_height_reg <= 7'd1;
            screen_width_reg    <= 11'd1;
            screen_height_reg   <= 11'd1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_COLOR_MARGIN:    color_margin_reg    <= cfg_data[7:0];
                REG_TEMPLATE_WIDTH:  template_width_reg  <= cfg_data[6:0];
                REG_TEMPLATE_HEIGHT: template_height_reg <= cfg_data[6:0];
                REG_SCREEN_WIDTH:    screen_width_reg    <= cfg_data;
                REG_SCREEN_HEIGHT:   screen_height_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    tmcm_cmd_t    cmd;
    tmcm_status_t status;
    tmcm_state_t  state;

    tmcm_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_cmd       (s_cmd),
        .s_last_pixel(s_last_pixel),
        .s_ready     (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .status      (status),
        .cmd         (cmd),
        .state       (state)
    );

    tmcm_datapath #(
        .TemplateMaxW(TemplateMaxW),
        .TemplateMaxH(TemplateMaxH),
        .ScreenMaxW  (ScreenMaxW),
        .ScreenMaxH  (ScreenMaxH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .pix_cmd        (s_cmd),
        .pix_rgb        (s_pixel_rgb),
        .pix_last       (s_last_pixel),
        .color_margin   (color_margin_reg),
        .template_width (template_width_reg),
        .template_height(template_height_reg),
        .screen_width   (screen_width_reg),
        .screen_height  (screen_height_reg),
        .status         (status),
        .found          (m_found)
    );

`ifndef SYNTHESIS
    a_ready_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("input ready while result pending");
    a_last_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_cmd == CMD_SCREEN && s_last_pixel) |=> !s_ready)
        else $error("search did not start");
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_found)))
        else $error("result dropped");
    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load_wr, cmd.check, cmd.set_result}))
        else $error("conflicting datapath commands");
    a_ready_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (state == ST_LOAD))
        else $error("input ready outside load state");
`endif
endmodule
